// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define KCT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// Check that a trigger implies a condition in the same cycle.
`define KCT_ASSERT_IMPLIES(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed: implication does not hold");

// Check that a trigger implies a condition in the following cycle.
`define KCT_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed: next-cycle implication does not hold");

`endif

// File: hw/rtl/kct_pkg.sv
// Shared constants, types and status codes of the keyed count table.
package kct_pkg;

   localparam int ENTRIES = 32;
   localparam int TYPE_W = 16;
   localparam int COUNT_W = 7;
   localparam int IDX_W = $clog2(ENTRIES);
   localparam int USED_W = $clog2(ENTRIES + 1);
   localparam logic [COUNT_W-1:0] MAX_PER_TYPE_RESET = COUNT_W'(100);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [USED_W-1:0] used_type;
   typedef logic [TYPE_W-1:0] key_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TOO_MANY   = 3'd1,
      ST_FULL       = 3'd2,
      ST_NOT_ENOUGH = 3'd3,
      ST_NONE       = 3'd4
   } status_type;

   typedef enum logic {
      OP_ADD    = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   // Update command broadcast to every cell of the row.
   typedef struct packed {
      logic      shift;    // cells at or above base take the upper neighbor
      idx_type   base;
      logic      write;    // the cell at wr_idx loads wr_key and wr_count
      idx_type   wr_idx;
      key_type   wr_key;
      count_type wr_count;
   } cell_ctl_type;

endpackage

// File: hw/rtl/keyed_count_table.sv
// Top level of the keyed count table: cell row, request decode and response register.
//
//   channel   direction  ports                                      word
//   req       in         req_valid/req_ready, opcode, type, qty     one request
//   rsp       out        rsp_valid/rsp_ready, status, count, used   one result
//   csr       in         csr_valid/csr_ready, csr_max_per_type      limit register
//
// A request is handled in an accept cycle, in which every cell compares its key
// against the request, and then in a decision cycle, in which the hits are merged,
// the outcome is decided and the row updated (write, append or shift-down delete).
// One request is in flight at a time; the next is taken the cycle after the
// decision, also while the result still waits in the response register.
// A stalled response holds the decision cycle; synchronous reset empties the table.
// The limit register is always ready; a csr write loads it.
`include "assert_macros.svh"

module keyed_count_table (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [0:0] req_opcode,
   input  logic [15:0] req_item_type,
   input  logic [6:0] req_quantity,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [6:0] rsp_count_after,
   output logic [5:0] rsp_entries_after,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_max_per_type
);

   // limit register
   kct_pkg::count_type max_ff;

   // request held across the decision cycle
   logic               busy_ff, busy_in;
   logic               op_ff;
   kct_pkg::key_type   key_ff;
   kct_pkg::count_type qty_ff;

   // table fill level
   kct_pkg::used_type  used_ff, used_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   kct_pkg::status_type    status_ff, status_in;
   kct_pkg::count_type     count_ff, count_in;
   kct_pkg::used_type      rsp_used_ff;

   logic                   req_fire;
   logic                   decide_fire;
   kct_pkg::cell_ctl_type  ctl, ctl_raw;

   // cell row
   kct_pkg::key_type   cell_key [kct_pkg::ENTRIES];
   kct_pkg::count_type cell_count [kct_pkg::ENTRIES];
   kct_pkg::count_type cell_hit_count [kct_pkg::ENTRIES];
   logic [kct_pkg::ENTRIES-1:0] hits;

   // merged hit
   logic               any_hit;
   kct_pkg::count_type hit_count;
   kct_pkg::idx_type   hit_idx;
   logic [kct_pkg::COUNT_W:0] sum;
   kct_pkg::count_type diff;

   assign req_ready   = !busy_ff;
   assign req_fire    = req_valid && req_ready;
   assign decide_fire = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign csr_ready   = 1'b1;

   // Build the row: each cell hands its content to the one below it.
   for (genvar i = 0; i < kct_pkg::ENTRIES; i++) begin : g_cell
      kct_pkg::key_type   up_key;
      kct_pkg::count_type up_count;
      if (i == kct_pkg::ENTRIES - 1) begin : g_top
         // top slot shifts in its own content; it lies beyond the fill level then
         assign up_key   = cell_key[i];
         assign up_count = cell_count[i];
      end else begin : g_mid
         assign up_key   = cell_key[i+1];
         assign up_count = cell_count[i+1];
      end
      kct_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (kct_pkg::idx_type'(i)),
         .used        (used_ff),
         .cmp_en      (req_fire),
         .cmp_key     (req_item_type[kct_pkg::TYPE_W-1:0]),
         .ctl         (ctl),
         .upper_key   (up_key),
         .upper_count (up_count),
         .key_out     (cell_key[i]),
         .count_out   (cell_count[i]),
         .hit         (hits[i]),
         .hit_count   (cell_hit_count[i])
      );
   end

   // Merge the one-hot hit: counts of non-hit cells read as zero.
   always_comb begin
      hit_count = '0;
      hit_idx   = '0;
      for (int i = 0; i < kct_pkg::ENTRIES; i++) begin
         hit_count = hit_count | cell_hit_count[i];
         hit_idx   = hit_idx | (hits[i] ? kct_pkg::idx_type'(i) : '0);
      end
      any_hit = |hits;
   end

   assign sum  = {1'b0, hit_count} + {1'b0, qty_ff};
   assign diff = hit_count - qty_ff;

   // Decide the outcome and the row update.
   always_comb begin
      ctl_raw          = '0;
      ctl_raw.wr_key   = key_ff;
      ctl_raw.base     = hit_idx;
      ctl_raw.wr_idx   = hit_idx;
      status_in        = kct_pkg::ST_OK;
      count_in         = '0;
      used_in          = used_ff;
      ctl_raw.wr_count = '0;
      case (kct_pkg::opcode_type'(op_ff))
         kct_pkg::OP_ADD: begin
            if (any_hit) begin
               if (sum > {1'b0, max_ff}) begin
                  status_in = kct_pkg::ST_TOO_MANY;
                  count_in  = hit_count;
               end else begin
                  ctl_raw.write    = 1'b1;
                  ctl_raw.wr_count = sum[kct_pkg::COUNT_W-1:0];
                  count_in         = sum[kct_pkg::COUNT_W-1:0];
               end
            end else if (used_ff == kct_pkg::used_type'(kct_pkg::ENTRIES)) begin
               status_in = kct_pkg::ST_FULL;
            end else begin
               // append behind the last entry
               ctl_raw.write    = 1'b1;
               ctl_raw.wr_idx   = used_ff[kct_pkg::IDX_W-1:0];
               ctl_raw.wr_count = qty_ff;
               count_in         = qty_ff;
               used_in          = used_ff + 1'b1;
            end
         end
         kct_pkg::OP_REMOVE: begin
            if (!any_hit) begin
               status_in = kct_pkg::ST_NONE;
            end else if (hit_count < qty_ff) begin
               status_in = kct_pkg::ST_NOT_ENOUGH;
               count_in  = hit_count;
            end else if (diff == '0) begin
               // empty entry: drop it and close the gap
               ctl_raw.shift = 1'b1;
               used_in       = used_ff - 1'b1;
            end else begin
               ctl_raw.write    = 1'b1;
               ctl_raw.wr_count = diff;
               count_in         = diff;
            end
         end
         default: begin
            status_in = kct_pkg::ST_OK;
         end
      endcase
   end

   // Apply the update only in the decision cycle.
   always_comb begin
      ctl       = ctl_raw;
      ctl.shift = ctl_raw.shift && decide_fire;
      ctl.write = ctl_raw.write && decide_fire;
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (decide_fire) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (decide_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_opcode[0];
         key_ff <= req_item_type[kct_pkg::TYPE_W-1:0];
         qty_ff <= req_quantity;
      end
      if (decide_fire) begin
         status_ff   <= status_in;
         count_ff    <= count_in;
         rsp_used_ff <= used_in;
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         max_ff       <= kct_pkg::MAX_PER_TYPE_RESET;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (decide_fire) begin
            used_ff <= used_in;
         end
         if (csr_valid && csr_ready) begin
            max_ff <= csr_max_per_type;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_count_after   = count_ff;
   assign rsp_entries_after = 6'(rsp_used_ff);

   `KCT_ASSERT_ALWAYS(a_single_hit, clock, reset, $onehot0(hits))
   `KCT_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= kct_pkg::used_type'(kct_pkg::ENTRIES))
   `KCT_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, busy_ff && !req_ready)
   `KCT_ASSERT_NEXT(a_decide_rsp, clock, reset, decide_fire, rsp_valid && !busy_ff)
   `KCT_ASSERT_IMPLIES(a_update_excl, clock, reset, ctl.shift, !ctl.write)

endmodule

// File: hw/rtl/kct_cell.sv
// One table slot: holds a key and count, matches a key, shifts down on delete.
module kct_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  kct_pkg::idx_type      cell_index,
   input  kct_pkg::used_type     used,
   input  logic                  cmp_en,
   input  kct_pkg::key_type      cmp_key,
   input  kct_pkg::cell_ctl_type ctl,
   input  kct_pkg::key_type      upper_key,
   input  kct_pkg::count_type    upper_count,
   output kct_pkg::key_type      key_out,
   output kct_pkg::count_type    count_out,
   output logic                  hit,
   output kct_pkg::count_type    hit_count
);

   kct_pkg::key_type   key_ff, key_in;
   kct_pkg::count_type count_ff, count_in;
   kct_pkg::count_type hit_count_ff, hit_count_in;
   logic               hit_ff, hit_in;
   logic               in_use;

   assign in_use = {1'b0, cell_index} < used;

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      if (ctl.shift && (cell_index >= ctl.base)) begin
         key_in   = upper_key;
         count_in = upper_count;
      end else if (ctl.write && (cell_index == ctl.wr_idx)) begin
         key_in   = ctl.wr_key;
         count_in = ctl.wr_count;
      end
   end

   always_comb begin
      hit_in       = hit_ff;
      hit_count_in = hit_count_ff;
      if (cmp_en) begin
         hit_in       = in_use && (key_ff == cmp_key);
         hit_count_in = hit_in ? count_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      count_ff     <= count_in;
      hit_count_ff <= hit_count_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign key_out   = key_ff;
   assign count_out = count_ff;
   assign hit       = hit_ff;
   assign hit_count = hit_ff ? hit_count_ff : '0;

endmodule
